FILE: rtl/smh_pkg.sv
// shared types, round constants and initial hash values for the sha-512 hasher
package smh_pkg;

    localparam int unsigned WordW   = 64;
    localparam int unsigned BlkWords = 16;
    localparam int unsigned HashWords = 8;
    localparam int unsigned Rounds  = 80;
    localparam int unsigned RndW    = 7;
    localparam int unsigned FillW   = 4;
    localparam int unsigned BytesW  = 61;

    localparam logic [WordW-1:0] MarkerWord = 64'h8000_0000_0000_0000;
    localparam logic [7:0]       MarkerByte = 8'h80;
    localparam logic [FillW-1:0] FillLast   = 4'd15;
    localparam logic [FillW-1:0] FillLenPos = 4'd14;
    localparam logic [RndW-1:0]  RndLast    = 7'd79;
    localparam logic [3:0]       FullBytes  = 4'd8;

    typedef struct packed {
        logic            push_in;
        logic            push_marker;
        logic            push_zero;
        logic            push_len;
        logic            round;
        logic            add_hash;
        logic            rearm;
        logic [RndW-1:0] round_idx;
        logic [2:0]      out_idx;
    } smh_cmd_t;

    typedef struct packed {
        logic blk_full;
        logic wrap;
        logic in_full_word;
    } smh_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } smh_state_t;

    function automatic logic [WordW-1:0] smh_iv(input logic [2:0] i);
        logic [WordW-1:0] r;
        case (i)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            default: r = 64'h5be0cd19137e2179;
        endcase
        return r;
    endfunction

    function automatic logic [WordW-1:0] smh_k(input logic [RndW-1:0] t);
        logic [WordW-1:0] r;
        case (t)
            7'd0:  r = 64'h428a2f98d728ae22;
            7'd1:  r = 64'h7137449123ef65cd;
            7'd2:  r = 64'hb5c0fbcfec4d3b2f;
            7'd3:  r = 64'he9b5dba58189dbbc;
            7'd4:  r = 64'h3956c25bf348b538;
            7'd5:  r = 64'h59f111f1b605d019;
            7'd6:  r = 64'h923f82a4af194f9b;
            7'd7:  r = 64'hab1c5ed5da6d8118;
            7'd8:  r = 64'hd807aa98a3030242;
            7'd9:  r = 64'h12835b0145706fbe;
            7'd10: r = 64'h243185be4ee4b28c;
            7'd11: r = 64'h550c7dc3d5ffb4e2;
            7'd12: r = 64'h72be5d74f27b896f;
            7'd13: r = 64'h80deb1fe3b1696b1;
            7'd14: r = 64'h9bdc06a725c71235;
            7'd15: r = 64'hc19bf174cf692694;
            7'd16: r = 64'he49b69c19ef14ad2;
            7'd17: r = 64'hefbe4786384f25e3;
            7'd18: r = 64'h0fc19dc68b8cd5b5;
            7'd19: r = 64'h240ca1cc77ac9c65;
            7'd20: r = 64'h2de92c6f592b0275;
            7'd21: r = 64'h4a7484aa6ea6e483;
            7'd22: r = 64'h5cb0a9dcbd41fbd4;
            7'd23: r = 64'h76f988da831153b5;
            7'd24: r = 64'h983e5152ee66dfab;
            7'd25: r = 64'ha831c66d2db43210;
            7'd26: r = 64'hb00327c898fb213f;
            7'd27: r = 64'hbf597fc7beef0ee4;
            7'd28: r = 64'hc6e00bf33da88fc2;
            7'd29: r = 64'hd5a79147930aa725;
            7'd30: r = 64'h06ca6351e003826f;
            7'd31: r = 64'h142929670a0e6e70;
            7'd32: r = 64'h27b70a8546d22ffc;
            7'd33: r = 64'h2e1b21385c26c926;
            7'd34: r = 64'h4d2c6dfc5ac42aed;
            7'd35: r = 64'h53380d139d95b3df;
            7'd36: r = 64'h650a73548baf63de;
            7'd37: r = 64'h766a0abb3c77b2a8;
            7'd38: r = 64'h81c2c92e47edaee6;
            7'd39: r = 64'h92722c851482353b;
            7'd40: r = 64'ha2bfe8a14cf10364;
            7'd41: r = 64'ha81a664bbc423001;
            7'd42: r = 64'hc24b8b70d0f89791;
            7'd43: r = 64'hc76c51a30654be30;
            7'd44: r = 64'hd192e819d6ef5218;
            7'd45: r = 64'hd69906245565a910;
            7'd46: r = 64'hf40e35855771202a;
            7'd47: r = 64'h106aa07032bbd1b8;
            7'd48: r = 64'h19a4c116b8d2d0c8;
            7'd49: r = 64'h1e376c085141ab53;
            7'd50: r = 64'h2748774cdf8eeb99;
            7'd51: r = 64'h34b0bcb5e19b48a8;
            7'd52: r = 64'h391c0cb3c5c95a63;
            7'd53: r = 64'h4ed8aa4ae3418acb;
            7'd54: r = 64'h5b9cca4f7763e373;
            7'd55: r = 64'h682e6ff3d6b2b8a3;
            7'd56: r = 64'h748f82ee5defb2fc;
            7'd57: r = 64'h78a5636f43172f60;
            7'd58: r = 64'h84c87814a1f0ab72;
            7'd59: r = 64'h8cc702081a6439ec;
            7'd60: r = 64'h90befffa23631e28;
            7'd61: r = 64'ha4506cebde82bde9;
            7'd62: r = 64'hbef9a3f7b2c67915;
            7'd63: r = 64'hc67178f2e372532b;
            7'd64: r = 64'hca273eceea26619c;
            7'd65: r = 64'hd186b8c721c0c207;
            7'd66: r = 64'heada7dd6cde0eb1e;
            7'd67: r = 64'hf57d4f7fee6ed178;
            7'd68: r = 64'h06f067aa72176fba;
            7'd69: r = 64'h0a637dc5a2c898a6;
            7'd70: r = 64'h113f9804bef90dae;
            7'd71: r = 64'h1b710b35131c471b;
            7'd72: r = 64'h28db77f523047d84;
            7'd73: r = 64'h32caab7b40c72493;
            7'd74: r = 64'h3c9ebe0a15c9bebc;
            7'd75: r = 64'h431d67c49c100d4c;
            7'd76: r = 64'h4cc5d4becb3e42b6;
            7'd77: r = 64'h597f299cfc657e2a;
            7'd78: r = 64'h5fcb6fab3ad6faec;
            7'd79: r = 64'h6c44198c4a475817;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/smh_datapath.sv
// block buffer, message schedule, round logic and hash state of the sha-512 hasher
module smh_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  smh_pkg::smh_cmd_t   cmd,
    output smh_pkg::smh_stat_t  stat,
    input  logic [63:0]         msg_word,
    input  logic [3:0]          valid_bytes,
    input  logic                end_of_message,
    output logic [63:0]         digest_word
);
    import smh_pkg::*;

    logic [WordW-1:0]  blk_reg  [BlkWords];
    logic [WordW-1:0]  v_reg    [HashWords];
    logic [WordW-1:0]  hash_reg [HashWords];
    logic [FillW-1:0]  fill_reg;
    logic [BytesW-1:0] bytes_reg;
    logic              wrap_reg;

    logic             full_word;
    logic [3:0]       in_nb;
    logic [WordW-1:0] in_word;
    logic [WordW-1:0] push_word;
    logic             push;
    logic [WordW-1:0] sched;
    logic [WordW-1:0] s0, s1, big0, big1, ch, maj, t1, t2;

    assign full_word = !end_of_message || (valid_bytes >= FullBytes);
    assign in_nb     = full_word ? FullBytes : valid_bytes;

    // keep message bytes; on a short final word place the marker byte right after them
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            if (4'(b) < in_nb)
                in_word[63-8*b -: 8] = msg_word[63-8*b -: 8];
            else if (4'(b) == in_nb)
                in_word[63-8*b -: 8] = MarkerByte;
            else
                in_word[63-8*b -: 8] = 8'h00;
        end
    end

    assign push = cmd.push_in | cmd.push_marker | cmd.push_zero | cmd.push_len;

    always_comb
    begin
        if (cmd.push_in)
            push_word = in_word;
        else if (cmd.push_marker)
            push_word = MarkerWord;
        else if (cmd.push_len)
            push_word = {bytes_reg, 3'b000};
        else
            push_word = '0;
    end

    // schedule and round functions
    assign s0 = {blk_reg[1][0], blk_reg[1][63:1]} ^ {blk_reg[1][7:0], blk_reg[1][63:8]}
              ^ (blk_reg[1] >> 7);
    assign s1 = {blk_reg[14][18:0], blk_reg[14][63:19]}
              ^ {blk_reg[14][60:0], blk_reg[14][63:61]} ^ (blk_reg[14] >> 6);
    assign sched = s1 + blk_reg[9] + s0 + blk_reg[0];

    assign big1 = {v_reg[4][13:0], v_reg[4][63:14]} ^ {v_reg[4][17:0], v_reg[4][63:18]}
                ^ {v_reg[4][40:0], v_reg[4][63:41]};
    assign ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1   = v_reg[7] + big1 + ch + smh_k(cmd.round_idx) + blk_reg[0];
    assign big0 = {v_reg[0][27:0], v_reg[0][63:28]} ^ {v_reg[0][33:0], v_reg[0][63:34]}
                ^ {v_reg[0][38:0], v_reg[0][63:39]};
    assign maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2   = big0 + maj;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int i = 0; i < BlkWords - 1; i++)
                blk_reg[i] <= blk_reg[i+1];
            blk_reg[BlkWords-1] <= push_word;
            if (fill_reg == FillLast)
            begin
                for (int i = 0; i < HashWords; i++)
                    v_reg[i] <= hash_reg[i];
            end
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < BlkWords - 1; i++)
                blk_reg[i] <= blk_reg[i+1];
            blk_reg[BlkWords-1] <= sched;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HashWords; i++)
                hash_reg[i] <= smh_iv(3'(i));
            fill_reg  <= '0;
            bytes_reg <= '0;
            wrap_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                fill_reg <= fill_reg + 4'd1;
            if (cmd.push_in)
                bytes_reg <= bytes_reg + BytesW'(in_nb);
            if (cmd.push_marker || (cmd.push_in && !full_word))
                wrap_reg <= (fill_reg == FillLenPos);
            else if (cmd.push_zero && fill_reg == FillLast)
                wrap_reg <= 1'b0;
            if (cmd.add_hash)
            begin
                for (int i = 0; i < HashWords; i++)
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
            end
            else if (cmd.rearm)
            begin
                for (int i = 0; i < HashWords; i++)
                    hash_reg[i] <= smh_iv(3'(i));
                fill_reg  <= '0;
                bytes_reg <= '0;
            end
        end
    end

    assign stat.blk_full     = (fill_reg == FillLast);
    assign stat.wrap         = wrap_reg;
    assign stat.in_full_word = full_word;
    assign digest_word       = hash_reg[cmd.out_idx];

endmodule

FILE: rtl/smh_ctrl.sv
// sequencing state machine of the sha-512 hasher
module smh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                end_of_message,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          word_index,
    output logic                last_word,
    input  smh_pkg::smh_stat_t  stat,
    output smh_pkg::smh_cmd_t   cmd
);
    import smh_pkg::*;

    smh_state_t      state_reg, state_next;
    logic [RndW-1:0] rnd_reg, rnd_next;
    logic [2:0]      idx_reg, idx_next;
    logic            mark_reg, mark_next;
    logic            pad_reg, pad_next;
    logic            fin_reg, fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            mark_reg  <= 1'b0;
            pad_reg   <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            mark_reg  <= mark_next;
            pad_reg   <= pad_next;
            fin_reg   <= fin_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        mark_next  = mark_reg;
        pad_next   = pad_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        cmd.round_idx = rnd_reg;
        cmd.out_idx   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.push_in = 1'b1;
                    if (end_of_message)
                    begin
                        pad_next  = 1'b1;
                        mark_next = stat.in_full_word;
                    end
                    if (stat.blk_full)
                    begin
                        state_next = ST_ROUND;
                        rnd_next   = '0;
                    end
                    else if (end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (mark_reg)
                begin
                    cmd.push_marker = 1'b1;
                    mark_next       = 1'b0;
                end
                else if (stat.blk_full && !stat.wrap)
                begin
                    cmd.push_len = 1'b1;
                    fin_next     = 1'b1;
                end
                else
                    cmd.push_zero = 1'b1;
                if (stat.blk_full)
                begin
                    state_next = ST_ROUND;
                    rnd_next   = '0;
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (rnd_reg == RndLast)
                    state_next = ST_ADD;
                else
                    rnd_next = rnd_reg + 7'd1;
            end
            ST_ADD:
            begin
                cmd.add_hash = 1'b1;
                if (fin_reg)
                begin
                    state_next = ST_OUT;
                    idx_next   = '0;
                    fin_next   = 1'b0;
                    pad_next   = 1'b0;
                end
                else if (pad_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    if (idx_reg == 3'd7)
                    begin
                        cmd.rearm  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = (state_reg == ST_OUT);
    assign word_index = idx_reg;
    assign last_word  = (idx_reg == 3'd7);

endmodule

FILE: rtl/sha512_message_hasher_unit.sv
// sha-512 hasher top level: message words in, eight digest words out
// One 64-bit message word is taken per cycle while in_stall is low. When a
// 16-word block is full, one shared round unit runs the 80 compression
// rounds at one round per cycle, then the add state adds the result into
// the hash state; no word is taken during compression or the add. On the
// final word the block appends padding and the bit length one word per
// cycle, runs one or two more compressions, and then offers the eight
// digest words, H0 first, one per transfer. A new message is taken once
// the eighth word has gone.
module sha512_message_hasher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] msg_word,
    input  logic [3:0]  valid_bytes,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import smh_pkg::*;

    smh_cmd_t  cmd;
    smh_stat_t stat;

    smh_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .word_index     (word_index),
        .last_word      (last_word),
        .stat           (stat),
        .cmd            (cmd)
    );

    smh_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .msg_word       (msg_word),
        .valid_bytes    (valid_bytes),
        .end_of_message (end_of_message),
        .digest_word    (digest_word)
    );

endmodule

FILE: rtl/smh_checker.sv
// port-level checks of the sha-512 hasher and their binding
module smh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(word_index))
        else $error("stalled digest word changed");

    // digest words come in order
    a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_word |=>
            out_valid && word_index == $past(word_index) + 3'd1)
        else $error("digest word index out of order");

    // digest ends after the eighth word
    a_out_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_word |=> !out_valid)
        else $error("digest continued past last word");

    // no input transfer while the digest is offered
    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken during digest output");

endmodule

bind sha512_message_hasher_unit smh_checker u_smh_checker (.*);

FILE: bench/tb_sha512_message_hasher_unit.sv
// testbench for the sha-512 message hasher: directed and random messages checked against a built-in predictor
class sha512_digest_board;
    logic [63:0] hash_st[8];
    logic [63:0] blk[16];
    int unsigned fill;
    logic [60:0] msg_bytes;
    logic [63:0] digest_q[$];
    int unsigned errors;

    function new();
        rearm();
        errors = 0;
    endfunction

    function void rearm();
        hash_st[0] = 64'h6a09e667f3bcc908; hash_st[1] = 64'hbb67ae8584caa73b;
        hash_st[2] = 64'h3c6ef372fe94f82b; hash_st[3] = 64'ha54ff53a5f1d36f1;
        hash_st[4] = 64'h510e527fade682d1; hash_st[5] = 64'h9b05688c2b3e6c1f;
        hash_st[6] = 64'h1f83d9abfb41bd6b; hash_st[7] = 64'h5be0cd19137e2179;
        fill = 0;
        msg_bytes = '0;
    endfunction

    function logic [63:0] rotr(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function void compress();
        logic [63:0] w[80];
        logic [63:0] v[8];
        logic [63:0] t1, t2, e, a;
        for (int t = 0; t < 16; t++) w[t] = blk[t];
        for (int t = 16; t < 80; t++)
            w[t] = (rotr(w[t-2], 19) ^ rotr(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
                 + (rotr(w[t-15], 1) ^ rotr(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
        for (int t = 0; t < 8; t++) v[t] = hash_st[t];
        for (int t = 0; t < 80; t++)
        begin
            e = v[4];
            a = v[0];
            t1 = v[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
               + ((e & v[5]) ^ (~e & v[6])) + smh_pkg::smh_k(t[6:0]) + w[t];
            t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
               + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++) hash_st[t] += v[t];
    endfunction

    function void push(logic [63:0] w);
        blk[fill] = w;
        fill = (fill + 1) % 16;
        if (fill == 0) compress();
    endfunction

    function void note_transfer(logic [63:0] word, logic [3:0] nb, logic eom);
        logic [63:0] mask;
        if (!eom || nb >= 8)
        begin
            msg_bytes += 8;
            push(word);
            if (!eom) return;
            push(smh_pkg::MarkerWord);
        end
        else
        begin
            mask = (nb == 0) ? 64'h0 : ~64'h0 << (64 - 8 * nb);
            msg_bytes += nb;
            push((word & mask) | (smh_pkg::MarkerWord >> (8 * nb)));
        end
        if (fill > 14)
            while (fill != 0) push(64'h0);
        while (fill < 14) push(64'h0);
        push(64'h0);
        push({msg_bytes, 3'b000});
        for (int i = 0; i < 8; i++) digest_q.push_back(hash_st[i]);
        rearm();
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_digest(logic [63:0] dw, logic [2:0] idx, logic lw);
        logic [63:0] exp_w;
        logic [2:0] exp_i;
        if (digest_q.size() == 0)
        begin
            report($sformatf("unexpected digest word %h", dw));
            return;
        end
        exp_i = 3'(7 - ((digest_q.size() - 1) % 8));
        exp_w = digest_q.pop_front();
        if (dw !== exp_w) report($sformatf("digest_word %h exp %h", dw, exp_w));
        if (idx !== exp_i) report($sformatf("word_index %0d exp %0d", idx, exp_i));
        if (lw !== (exp_i == 3'd7)) report($sformatf("last_word %b at %0d", lw, exp_i));
    endtask
endclass

module tb_sha512_message_hasher_unit;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [63:0] msg_word = '0;
    logic [3:0]  valid_bytes = 4'd8;
    logic        end_of_message = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha512_digest_board board = new();
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    bit driving_done = 0;

    sha512_message_hasher_unit u_top (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_transfer(msg_word, valid_bytes, end_of_message);
            if (out_valid && !out_stall)
                board.check_digest(digest_word, word_index, last_word);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 20000)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver stall pattern: phases of none, light and heavy stalling
    always @(negedge clk)
    begin
        case (($time / 4000) % 3)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task send_word(logic [63:0] w, logic [3:0] nb, logic eom);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        msg_word <= w;
        valid_bytes <= nb;
        end_of_message <= eom;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task send_message(int unsigned words, logic [3:0] nb);
        for (int unsigned i = 0; i < words; i++)
            send_word({$urandom, $urandom}, (i + 1 == words) ? nb : 4'($urandom), i + 1 == words);
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed: empty message, all-ones and zero words, every byte count from 0 to 8
        send_word(64'h0, 4'd0, 1'b1);
        send_word(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
        send_word(64'h0, 4'd8, 1'b1);
        for (int nb = 1; nb <= 7; nb++) send_word({$urandom, $urandom}, 4'(nb), 1'b1);
        send_word(64'hffff_ffff_ffff_ffff, 4'd15, 1'b1);
        send_word(64'h0, 4'd9, 1'b0);
        send_word(64'h1234, 4'd1, 1'b1);
        send_message(14, 4'd8);
        send_message(15, 4'd0);
        for (int m = 0; m < 22; m++)
        begin
            if ($urandom_range(0, 4) == 0) send_message($urandom_range(14, 17), 4'($urandom));
            else send_message($urandom_range(1, 6), 4'($urandom));
        end
        in_valid <= 1'b0;
        driving_done = 1;
    end

    initial
    begin
        wait (driving_done);
        while (board.digest_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: files.f
rtl/smh_pkg.sv
rtl/smh_datapath.sv
rtl/smh_ctrl.sv
rtl/sha512_message_hasher_unit.sv
rtl/smh_checker.sv
bench/tb_sha512_message_hasher_unit.sv
